// ===== src/jls_pkg.sv =====
// Shared types, constants and the opcode decoder of the JVM load/store unit.
package jls_pkg;

  // Sizes of the local slots and the operand stack
  localparam int STACK_DEPTH = 16;
  localparam int LOCAL_SLOTS = 256;
  localparam int SP_W        = $clog2(STACK_DEPTH + 1);
  localparam int SP_IDX_W    = $clog2(STACK_DEPTH);
  localparam int SLOT_W      = $clog2(LOCAL_SLOTS);
  localparam int ROWS        = LOCAL_SLOTS / 2;
  localparam int ROW_W       = $clog2(ROWS);
  localparam int COUNT_W     = 5;

  // Opcodes
  localparam logic [7:0] OP_NOP          = 8'h00;
  localparam logic [7:0] OP_ACONST_NULL  = 8'h01;
  localparam logic [7:0] OP_ICONST_5     = 8'h08;
  localparam logic [7:0] OP_LCONST_1     = 8'h0A;
  localparam logic [7:0] OP_LCONST_0     = 8'h09;
  localparam logic [7:0] OP_FCONST_0     = 8'h0B;
  localparam logic [7:0] OP_FCONST_1     = 8'h0C;
  localparam logic [7:0] OP_FCONST_2     = 8'h0D;
  localparam logic [7:0] OP_DCONST_0     = 8'h0E;
  localparam logic [7:0] OP_DCONST_1     = 8'h0F;
  localparam logic [7:0] OP_BIPUSH       = 8'h10;
  localparam logic [7:0] OP_SIPUSH       = 8'h11;
  localparam logic [7:0] OP_LDC          = 8'h12;
  localparam logic [7:0] OP_LDC_W        = 8'h13;
  localparam logic [7:0] OP_LDC2_W       = 8'h14;
  localparam logic [7:0] OP_ILOAD        = 8'h15;
  localparam logic [7:0] OP_ALOAD        = 8'h19;
  localparam logic [7:0] OP_ILOAD_0      = 8'h1A;
  localparam logic [7:0] OP_ALOAD_3      = 8'h2D;
  localparam logic [7:0] OP_ISTORE       = 8'h36;
  localparam logic [7:0] OP_ASTORE       = 8'h3A;
  localparam logic [7:0] OP_ISTORE_0     = 8'h3B;
  localparam logic [7:0] OP_ASTORE_3     = 8'h4E;

  // Constant values
  localparam logic [31:0] FLOAT_ONE  = 32'h3F80_0000;
  localparam logic [31:0] FLOAT_TWO  = 32'h4000_0000;
  localparam logic [63:0] DOUBLE_ONE = 64'h3FF0_0000_0000_0000;

  // Value kinds of the typed load/store forms
  localparam logic [2:0] KIND_LONG   = 3'd1;
  localparam logic [2:0] KIND_DOUBLE = 3'd3;

  // Pool entry kinds
  localparam logic [2:0] POOL_REF    = 3'd2;
  localparam logic [2:0] POOL_LONG   = 3'd3;
  localparam logic [2:0] POOL_DOUBLE = 3'd4;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_UNKNOWN   = 3'd1,
    ST_OVERFLOW  = 3'd2,
    ST_UNDERFLOW = 3'd3,
    ST_BAD_INDEX = 3'd4,
    ST_BAD_POOL  = 3'd5
  } jls_status_t;

  typedef enum logic [2:0] {
    CLS_NOP,
    CLS_PUSH,
    CLS_LOAD,
    CLS_STORE,
    CLS_UNKNOWN
  } jls_cls_t;

  typedef struct packed {
    logic [7:0]  operation;
    logic [15:0] operand_bytes;
    logic        wide_prefix;
    logic [2:0]  pool_kind;
    logic [63:0] pool_value;
  } jls_in_t;

  typedef struct packed {
    jls_status_t        status;
    logic [63:0]        top_value;
    logic               top_is_wide;
    logic [COUNT_W-1:0] stack_count;
  } jls_out_t;

  // Decoded instruction
  typedef struct packed {
    jls_cls_t    cls;
    logic        wide;
    logic        bad_idx;
    logic        bad_pool;
    logic [15:0] idx;
    logic [63:0] val;
  } jls_dec_t;

  // Write word into the local slots
  typedef struct packed {
    logic              en;
    logic              wide;
    logic [SLOT_W-1:0] idx;
    logic [63:0]       data;
  } jls_wr_t;

  typedef struct packed {
    logic        wide;
    logic [63:0] val;
  } jls_entry_t;

  // Classify one opcode, pick its slot index and immediate value
  function automatic jls_dec_t jls_decode(jls_in_t w);
    jls_dec_t    d;
    logic [15:0] lidx;
    logic [7:0]  rel;
    logic [2:0]  kind;
    logic [16:0] idx_ext;
    d        = '0;
    d.cls    = CLS_UNKNOWN;
    lidx     = w.wide_prefix ? w.operand_bytes : {8'd0, w.operand_bytes[7:0]};
    rel      = 8'd0;
    kind     = 3'd0;
    idx_ext  = 17'd0;
    priority if (w.operation == OP_NOP) begin
      d.cls = CLS_NOP;
    end else if (w.operation == OP_ACONST_NULL) begin
      d.cls = CLS_PUSH;
    end else if (w.operation <= OP_ICONST_5) begin
      d.cls = CLS_PUSH;
      d.val = {32'd0, 32'(w.operation) - 32'd3};
    end else if (w.operation <= OP_LCONST_1) begin
      d.cls  = CLS_PUSH;
      d.wide = 1'b1;
      d.val  = {63'd0, w.operation == OP_LCONST_1};
    end else if (w.operation == OP_FCONST_0) begin
      d.cls = CLS_PUSH;
    end else if (w.operation == OP_FCONST_1) begin
      d.cls = CLS_PUSH;
      d.val = {32'd0, FLOAT_ONE};
    end else if (w.operation == OP_FCONST_2) begin
      d.cls = CLS_PUSH;
      d.val = {32'd0, FLOAT_TWO};
    end else if (w.operation == OP_DCONST_0) begin
      d.cls  = CLS_PUSH;
      d.wide = 1'b1;
    end else if (w.operation == OP_DCONST_1) begin
      d.cls  = CLS_PUSH;
      d.wide = 1'b1;
      d.val  = DOUBLE_ONE;
    end else if (w.operation == OP_BIPUSH) begin
      d.cls = CLS_PUSH;
      d.val = {32'd0, {24{w.operand_bytes[7]}}, w.operand_bytes[7:0]};
    end else if (w.operation == OP_SIPUSH) begin
      d.cls = CLS_PUSH;
      d.val = {32'd0, {16{w.operand_bytes[15]}}, w.operand_bytes};
    end else if (w.operation == OP_LDC || w.operation == OP_LDC_W) begin
      d.cls      = CLS_PUSH;
      d.bad_pool = w.pool_kind > POOL_REF;
      d.val      = {32'd0, w.pool_value[31:0]};
    end else if (w.operation == OP_LDC2_W) begin
      d.cls      = CLS_PUSH;
      d.wide     = 1'b1;
      d.bad_pool = !(w.pool_kind == POOL_LONG || w.pool_kind == POOL_DOUBLE);
      d.val      = w.pool_value;
    end else if (w.operation <= OP_ALOAD) begin
      d.cls = CLS_LOAD;
      kind  = 3'(w.operation - OP_ILOAD);
      d.idx = lidx;
    end else if (w.operation <= OP_ALOAD_3) begin
      d.cls = CLS_LOAD;
      rel   = w.operation - OP_ILOAD_0;
      kind  = rel[4:2];
      d.idx = {14'd0, rel[1:0]};
    end else if (w.operation >= OP_ISTORE && w.operation <= OP_ASTORE) begin
      d.cls = CLS_STORE;
      kind  = 3'(w.operation - OP_ISTORE);
      d.idx = lidx;
    end else if (w.operation >= OP_ISTORE_0 && w.operation <= OP_ASTORE_3) begin
      d.cls = CLS_STORE;
      rel   = w.operation - OP_ISTORE_0;
      kind  = rel[4:2];
      d.idx = {14'd0, rel[1:0]};
    end else begin
      d.cls = CLS_UNKNOWN;
    end
    // Check the slot range for loads and stores
    if (d.cls == CLS_LOAD || d.cls == CLS_STORE) begin
      d.wide    = (kind == KIND_LONG) || (kind == KIND_DOUBLE);
      idx_ext   = {1'b0, d.idx} + {16'd0, d.wide};
      d.bad_idx = idx_ext >= 17'(LOCAL_SLOTS);
    end
    return d;
  endfunction

endpackage

// ===== src/jls_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module jls_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 128
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write and registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== src/jls_locals.sv =====
// Local-variable slots: even/odd RAM banks, valid bits and write forwarding.
module jls_locals
  import jls_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic [SLOT_W-1:0] rd_idx,
  input  jls_wr_t           wr,
  output logic [31:0]       rd_lo,
  output logic [31:0]       rd_hi
);

  logic [ROW_W-1:0] rd_row_e, rd_row_o;
  logic [ROW_W-1:0] rd_row_e_r, rd_row_o_r;
  logic             rd_odd_r;
  logic [ROW_W-1:0] wr_row_e, wr_row_o;
  logic             we_e, we_o;
  logic [31:0]      wd_e, wd_o;
  logic [31:0]      ram_e, ram_o;
  logic [31:0]      dat_e, dat_o;
  logic [ROWS-1:0]  vld_e_r, vld_o_r;
  logic             fwd_e_en_r, fwd_o_en_r;
  logic [ROW_W-1:0] fwd_e_row_r, fwd_o_row_r;
  logic [31:0]      fwd_e_dat_r, fwd_o_dat_r;

  // Slot i sits in bank i[0]; a pair starting on an odd slot wraps to the next even row
  assign rd_row_o = rd_idx[SLOT_W-1:1];
  assign rd_row_e = rd_idx[SLOT_W-1:1] + ROW_W'(rd_idx[0]);
  assign wr_row_o = wr.idx[SLOT_W-1:1];
  assign wr_row_e = wr.idx[SLOT_W-1:1] + ROW_W'(wr.idx[0]);

  // Route low and high words to the banks
  assign we_e = wr.en && (!wr.idx[0] || wr.wide);
  assign we_o = wr.en && (wr.idx[0] || wr.wide);
  assign wd_e = wr.idx[0] ? wr.data[63:32] : wr.data[31:0];
  assign wd_o = wr.idx[0] ? wr.data[31:0] : wr.data[63:32];

  jls_ram #(.WIDTH(32), .DEPTH(ROWS)) u_bank_e (
    .clk   (clk),
    .we    (we_e),
    .waddr (wr_row_e),
    .wdata (wd_e),
    .raddr (rd_row_e),
    .rdata (ram_e)
  );

  jls_ram #(.WIDTH(32), .DEPTH(ROWS)) u_bank_o (
    .clk   (clk),
    .we    (we_o),
    .waddr (wr_row_o),
    .wdata (wd_o),
    .raddr (rd_row_o),
    .rdata (ram_o)
  );

  // Hold the read address alongside the registered read data
  always_ff @(posedge clk) begin
    rd_row_e_r <= rd_row_e;
    rd_row_o_r <= rd_row_o;
    rd_odd_r   <= rd_idx[0];
    fwd_e_row_r <= wr_row_e;
    fwd_o_row_r <= wr_row_o;
    fwd_e_dat_r <= wd_e;
    fwd_o_dat_r <= wd_o;
  end

  // Valid bits and forward enables; unwritten slots read as zero
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_e_r    <= '0;
      vld_o_r    <= '0;
      fwd_e_en_r <= 1'b0;
      fwd_o_en_r <= 1'b0;
    end else begin
      fwd_e_en_r <= we_e;
      fwd_o_en_r <= we_o;
      if (we_e) begin
        vld_e_r[wr_row_e] <= 1'b1;
      end
      if (we_o) begin
        vld_o_r[wr_row_o] <= 1'b1;
      end
    end
  end

  // Take the write that landed with the read, else the RAM word if valid
  always_comb begin
    if (fwd_e_en_r && fwd_e_row_r == rd_row_e_r) begin
      dat_e = fwd_e_dat_r;
    end else begin
      dat_e = vld_e_r[rd_row_e_r] ? ram_e : 32'd0;
    end
    if (fwd_o_en_r && fwd_o_row_r == rd_row_o_r) begin
      dat_o = fwd_o_dat_r;
    end else begin
      dat_o = vld_o_r[rd_row_o_r] ? ram_o : 32'd0;
    end
  end

  assign rd_lo = rd_odd_r ? dat_o : dat_e;
  assign rd_hi = rd_odd_r ? dat_e : dat_o;

endmodule

// ===== src/jvm_load_store_unit.sv =====
// Top level of the JVM load/store unit: input register, execute stage and result register.
// The result strobe of an instruction rises once it has passed the input register and then the result register.
// Throughput: one instruction per cycle; busy is always low and the result cannot be stalled.
// The local-slot read is issued at the input edge; the stack top lives in a register.
// Reset (synchronous, rst_n low): empties the stack, marks every local slot as zero
// through valid bits, and drops any instruction in flight.
module jvm_load_store_unit
  import jls_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     start,
  output logic     busy,
  input  jls_in_t  in_word,
  output logic     out_valid,
  output jls_out_t out_word
);

  jls_dec_t         dec_in;
  jls_dec_t         dec_r;
  logic             v_r;
  logic [31:0]      ld_lo, ld_hi;
  jls_wr_t          wr;

  logic [SP_W-1:0]  sp_r, sp_nxt;
  jls_entry_t       top_r, top_nxt;
  jls_entry_t       body_r [STACK_DEPTH];
  jls_entry_t       below;
  jls_entry_t       push_ent;
  logic             push, pop;
  logic             full, empty;
  jls_status_t      status;
  logic             out_valid_r;
  jls_out_t         out_r, out_nxt;

  assign busy = 1'b0;

  // Decode at the input and start the slot read
  assign dec_in = jls_decode(in_word);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else begin
      v_r <= start && !busy;
    end
  end

  always_ff @(posedge clk) begin
    dec_r <= dec_in;
  end

  jls_locals u_locals (
    .clk    (clk),
    .rst_n  (rst_n),
    .rd_idx (dec_in.idx[SLOT_W-1:0]),
    .wr     (wr),
    .rd_lo  (ld_lo),
    .rd_hi  (ld_hi)
  );

  // Check the stack and pick the action
  assign full  = sp_r == SP_W'(STACK_DEPTH);
  assign empty = sp_r == '0;
  assign below = (sp_r >= SP_W'(2)) ? body_r[SP_IDX_W'(sp_r - SP_W'(2))] : '0;

  always_comb begin
    status        = ST_OK;
    push          = 1'b0;
    pop           = 1'b0;
    push_ent.wide = dec_r.wide;
    push_ent.val  = dec_r.val;
    if (dec_r.cls == CLS_LOAD) begin
      push_ent.val = dec_r.wide ? {ld_hi, ld_lo} : {32'd0, ld_lo};
    end
    unique case (dec_r.cls)
      CLS_NOP: begin
        status = ST_OK;
      end
      CLS_PUSH: begin
        if (dec_r.bad_pool) begin
          status = ST_BAD_POOL;
        end else if (full) begin
          status = ST_OVERFLOW;
        end else begin
          push = v_r;
        end
      end
      CLS_LOAD: begin
        if (dec_r.bad_idx) begin
          status = ST_BAD_INDEX;
        end else if (full) begin
          status = ST_OVERFLOW;
        end else begin
          push = v_r;
        end
      end
      CLS_STORE: begin
        if (dec_r.bad_idx) begin
          status = ST_BAD_INDEX;
        end else if (empty) begin
          status = ST_UNDERFLOW;
        end else begin
          pop = v_r;
        end
      end
      default: begin
        status = ST_UNKNOWN;
      end
    endcase
  end

  // Advance the stack top and depth
  always_comb begin
    sp_nxt  = sp_r;
    top_nxt = top_r;
    if (push) begin
      sp_nxt  = sp_r + SP_W'(1);
      top_nxt = push_ent;
    end else if (pop) begin
      sp_nxt  = sp_r - SP_W'(1);
      top_nxt = below;
    end
  end

  // Store the popped word into the local slots
  always_comb begin
    wr.en   = pop;
    wr.wide = dec_r.wide;
    wr.idx  = dec_r.idx[SLOT_W-1:0];
    wr.data = top_r.val;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sp_r  <= '0;
      top_r <= '0;
    end else begin
      sp_r  <= sp_nxt;
      top_r <= top_nxt;
    end
  end

  // Spill the old top below the new one on a push
  always_ff @(posedge clk) begin
    if (push && !empty) begin
      body_r[SP_IDX_W'(sp_r - SP_W'(1))] <= top_r;
    end
  end

  // Build the result word
  always_comb begin
    out_nxt.status      = status;
    out_nxt.top_value   = top_nxt.val;
    out_nxt.top_is_wide = top_nxt.wide;
    out_nxt.stack_count = COUNT_W'(sp_nxt);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= v_r;
    end
  end

  always_ff @(posedge clk) begin
    out_r <= out_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_word  = out_r;

`ifndef SYNTHESIS
  // Reported depth matches the stack pointer left behind
  a_count_matches_sp: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> out_r.stack_count == COUNT_W'(sp_r))
    else $error("stack_count does not match stack pointer");

  // An empty stack shows a zero top
  a_empty_top_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_r.stack_count == '0) |-> (out_r.top_value == '0 && !out_r.top_is_wide))
    else $error("empty stack reports a nonzero top");

  // A failed instruction leaves the depth unchanged
  a_fail_keeps_sp: assert property (@(posedge clk) disable iff (!rst_n)
    (v_r && status != ST_OK) |=> sp_r == $past(sp_r))
    else $error("failed instruction moved the stack pointer");

  // Stack pointer never exceeds the depth
  a_sp_bound: assert property (@(posedge clk) disable iff (!rst_n)
    sp_r <= SP_W'(STACK_DEPTH))
    else $error("stack pointer beyond stack depth");
`endif

endmodule
